// ===== hdl/ild_pkg.sv =====
package ild_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 32;
  localparam int OPC_W        = 3;
  localparam int STS_W        = 2;
  localparam int LEN_OUT_W    = 7;

  localparam logic [OPC_W-1:0] OP_GET        = 3'd0;
  localparam logic [OPC_W-1:0] OP_INS_HEAD   = 3'd1;
  localparam logic [OPC_W-1:0] OP_INS_TAIL   = 3'd2;
  localparam logic [OPC_W-1:0] OP_INS_BEFORE = 3'd3;
  localparam logic [OPC_W-1:0] OP_DELETE     = 3'd4;

  localparam logic [STS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [STS_W-1:0]        status;
    logic [LEN_OUT_W-1:0]    length;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SETUP_INS,
    DP_SETUP_DEL,
    DP_READ_UP,
    DP_WRITE_UP,
    DP_READ_DN,
    DP_WRITE_DN,
    DP_PUT,
    DP_DROP,
    DP_READ_GET,
    DP_EMIT_GET,
    DP_EMIT_INVALID,
    DP_EMIT_FULL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic get_ok;
    logic ins_go;
    logic ins_full;
    logic del_ok;
    logic up_more;
    logic dn_more;
  } dp_sts_t;

endpackage

// ===== hdl/ild_ram.sv =====
module ild_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ild_ctrl.sv =====
module ild_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ild_pkg::dp_sts_t sts,
  output ild_pkg::dp_ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_UP_CHK   = 7'b0000100,
    S_UP_WR    = 7'b0001000,
    S_DN_CHK   = 7'b0010000,
    S_DN_WR    = 7'b0100000,
    S_GET_WAIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op    = ild_pkg::DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op    = ild_pkg::DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.get_ok) begin
          ctl.op    = ild_pkg::DP_READ_GET;
          state_nxt = S_GET_WAIT;
        end else if (sts.ins_go) begin
          ctl.op    = ild_pkg::DP_SETUP_INS;
          state_nxt = S_UP_CHK;
        end else if (sts.del_ok) begin
          ctl.op    = ild_pkg::DP_SETUP_DEL;
          state_nxt = S_DN_CHK;
        end else if (sts.ins_full) begin
          ctl.op    = ild_pkg::DP_EMIT_FULL;
          state_nxt = S_IDLE;
        end else begin
          ctl.op    = ild_pkg::DP_EMIT_INVALID;
          state_nxt = S_IDLE;
        end
      end
      S_UP_CHK: begin
        if (sts.up_more) begin
          ctl.op    = ild_pkg::DP_READ_UP;
          state_nxt = S_UP_WR;
        end else begin
          ctl.op    = ild_pkg::DP_PUT;
          state_nxt = S_IDLE;
        end
      end
      S_UP_WR: begin
        ctl.op    = ild_pkg::DP_WRITE_UP;
        state_nxt = S_UP_CHK;
      end
      S_DN_CHK: begin
        if (sts.dn_more) begin
          ctl.op    = ild_pkg::DP_READ_DN;
          state_nxt = S_DN_WR;
        end else begin
          ctl.op    = ild_pkg::DP_DROP;
          state_nxt = S_IDLE;
        end
      end
      S_DN_WR: begin
        ctl.op    = ild_pkg::DP_WRITE_DN;
        state_nxt = S_DN_CHK;
      end
      S_GET_WAIT: begin
        ctl.op    = ild_pkg::DP_EMIT_GET;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/ild_dp.sv =====
module ild_dp #(
  parameter int CAPACITY = ild_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ild_pkg::in_item_t   in_item,
  input  ild_pkg::dp_ctl_t    ctl,
  output ild_pkg::dp_sts_t    sts,
  output logic                out_valid,
  output ild_pkg::out_item_t  out_item
);

  localparam int AW          = $clog2(CAPACITY);
  localparam int LEN_W       = $clog2(CAPACITY + 1);
  localparam int LEN_OUT_PAD = ild_pkg::LEN_OUT_W;

  ild_pkg::in_item_t  cmd_r;
  ild_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      target_r, target_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [ild_pkg::VAL_W-1:0]      ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [ild_pkg::VAL_W-1:0]      ram_rdata;

  logic signed [ild_pkg::POS_W:0] pos_ext;
  logic signed [ild_pkg::POS_W:0] cnt_ext;
  logic                           in_range;
  logic                           is_ins;
  logic                           ins_bad;
  logic                           full;
  logic [AW-1:0]                  ins_target;
  logic [LEN_W+LEN_OUT_PAD-1:0]   len_ext;
  logic [LEN_W:0]                 idx_plus1;

  ild_ram #(
    .WIDTH(ild_pkg::VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_ext  = {cmd_r.position[ild_pkg::POS_W-1], cmd_r.position};
  assign cnt_ext  = signed'((ild_pkg::POS_W + 1)'(count_r));
  assign in_range = !cmd_r.position[ild_pkg::POS_W-1] && (pos_ext < cnt_ext);
  assign full     = (count_r == LEN_W'(CAPACITY));
  assign is_ins   = (cmd_r.opcode == ild_pkg::OP_INS_HEAD) ||
                    (cmd_r.opcode == ild_pkg::OP_INS_TAIL) ||
                    (cmd_r.opcode == ild_pkg::OP_INS_BEFORE);
  assign ins_bad  = (cmd_r.opcode == ild_pkg::OP_INS_BEFORE) && (pos_ext > cnt_ext);

  always_comb begin
    case (cmd_r.opcode)
      ild_pkg::OP_INS_TAIL: begin
        ins_target = AW'(count_r);
      end
      ild_pkg::OP_INS_BEFORE: begin
        if (cmd_r.position <= 0) begin
          ins_target = '0;
        end else begin
          ins_target = cmd_r.position[AW-1:0];
        end
      end
      default: begin
        ins_target = '0;
      end
    endcase
  end

  assign idx_plus1 = (LEN_W + 1)'(idx_r) + (LEN_W + 1)'(1);

  assign sts.get_ok   = (cmd_r.opcode == ild_pkg::OP_GET) && in_range;
  assign sts.del_ok   = (cmd_r.opcode == ild_pkg::OP_DELETE) && in_range;
  assign sts.ins_go   = is_ins && !ins_bad && !full;
  assign sts.ins_full = is_ins && !ins_bad && full;
  assign sts.up_more  = (idx_r > target_r);
  assign sts.dn_more  = (idx_plus1 < (LEN_W + 1)'(count_r));

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    idx_nxt       = idx_r;
    target_nxt    = target_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (ctl.op)
      ild_pkg::DP_SETUP_INS: begin
        idx_nxt    = AW'(count_r);
        target_nxt = ins_target;
      end
      ild_pkg::DP_SETUP_DEL: begin
        idx_nxt = cmd_r.position[AW-1:0];
      end
      ild_pkg::DP_READ_UP: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r - AW'(1);
      end
      ild_pkg::DP_WRITE_UP: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r - AW'(1);
      end
      ild_pkg::DP_READ_DN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r + AW'(1);
      end
      ild_pkg::DP_WRITE_DN: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
      ild_pkg::DP_READ_GET: begin
        ram_re    = 1'b1;
        ram_raddr = cmd_r.position[AW-1:0];
      end
      ild_pkg::DP_PUT: begin
        ram_we             = 1'b1;
        ram_waddr          = target_r;
        ram_wdata          = cmd_r.item_value;
        count_nxt          = count_r + LEN_W'(1);
        out_valid_nxt      = 1'b1;
        out_nxt.read_value = '0;
        out_nxt.status     = ild_pkg::ST_DONE;
      end
      ild_pkg::DP_DROP: begin
        count_nxt          = count_r - LEN_W'(1);
        out_valid_nxt      = 1'b1;
        out_nxt.read_value = '0;
        out_nxt.status     = ild_pkg::ST_DONE;
      end
      ild_pkg::DP_EMIT_GET: begin
        out_valid_nxt      = 1'b1;
        out_nxt.read_value = ram_rdata;
        out_nxt.status     = ild_pkg::ST_DONE;
      end
      ild_pkg::DP_EMIT_INVALID: begin
        out_valid_nxt  = 1'b1;
        out_nxt.status = ild_pkg::ST_INVALID;
        if (cmd_r.opcode == ild_pkg::OP_GET) begin
          out_nxt.read_value = '1;
        end else begin
          out_nxt.read_value = '0;
        end
      end
      ild_pkg::DP_EMIT_FULL: begin
        out_valid_nxt      = 1'b1;
        out_nxt.read_value = '0;
        out_nxt.status     = ild_pkg::ST_FULL;
      end
      default: begin
      end
    endcase
    out_nxt.length = len_ext[ild_pkg::LEN_OUT_W-1:0];
  end

  assign len_ext = {{LEN_OUT_PAD{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == ild_pkg::DP_LOAD) begin
      cmd_r <= in_item;
    end
    idx_r    <= idx_nxt;
    target_r <= target_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/indexed_list_insert_delete.sv =====
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, kept in one
// single-port-write RAM. A command is accepted when start is high and busy is low; each
// command gives exactly one result, shown for one cycle with out_valid, which the receiver
// must take as it comes. Entries move one RAM location at a time (a read, then a write back
// one place over), so the command time is set by that shift loop: an insert at index p into
// a list of n entries shifts n - p entries, a delete at index p shifts n - 1 - p, and an
// invalid or full-list command or a get shifts none. A new command may be accepted while the
// previous result is on the output ports.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ild_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ild_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ild_pkg::out_item_t out_item
);

  ild_pkg::dp_ctl_t ctl;
  ild_pkg::dp_sts_t sts;

  ild_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .ctl  (ctl)
  );

  ild_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ===== hdl/ild_checker.sv =====
module ild_checker #(
  parameter int CAPACITY = ild_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ild_pkg::out_item_t out_item
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam logic [LEN_W+ild_pkg::LEN_OUT_W-1:0] CAP_EXT =
    (LEN_W + ild_pkg::LEN_OUT_W)'(CAPACITY);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results on consecutive cycles");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ild_pkg::ST_DONE) ||
                  (out_item.status == ild_pkg::ST_INVALID) ||
                  (out_item.status == ild_pkg::ST_FULL))
    else $error("undefined status code");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ild_pkg::ST_FULL) |->
      out_item.length == CAP_EXT[ild_pkg::LEN_OUT_W-1:0])
    else $error("full status with list not at capacity");

endmodule

bind indexed_list_insert_delete ild_checker #(.CAPACITY(CAPACITY)) u_ild_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CAP            = ild_pkg::CAPACITY_DEF;
  localparam int MAX_CMD_CYCLES = 3 + 2 * CAP;
  localparam int MAX_REPORTS    = 10;

  localparam logic [ild_pkg::OPC_W-1:0] OP_BAD_LO  = 3'd5;
  localparam logic [ild_pkg::OPC_W-1:0] OP_BAD_MID = 3'd6;
  localparam logic [ild_pkg::OPC_W-1:0] OP_BAD_HI  = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ild_pkg::in_item_t  in_item;
  logic               out_valid;
  ild_pkg::out_item_t out_item;

  logic [ild_pkg::VAL_W-1:0] list_mem [CAP];
  int                        list_len;
  ild_pkg::out_item_t        result_q [$];

  int idle_pct;
  bit grow_mode;
  int mismatches;
  int results_checked;
  int cmds_sent;
  int full_drops;
  int invalid_hits;

  indexed_list_insert_delete #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ild_pkg::STS_W-1:0] list_insert(
    int                        slot,
    logic [ild_pkg::VAL_W-1:0] v
  );
    int i;
    if (list_len >= CAP) return ild_pkg::ST_FULL;
    if (slot > list_len) return ild_pkg::ST_INVALID;
    for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
    list_mem[slot] = v;
    list_len++;
    return ild_pkg::ST_DONE;
  endfunction

  function automatic ild_pkg::out_item_t apply_list_cmd(ild_pkg::in_item_t cmd);
    ild_pkg::out_item_t r;
    int                 p;
    int                 i;
    p            = cmd.position;
    r.read_value = '0;
    r.status     = ild_pkg::ST_DONE;
    case (cmd.opcode)
      ild_pkg::OP_GET: begin
        if (p >= 0 && p < list_len) begin
          r.read_value = list_mem[p];
        end else begin
          r.read_value = '1;
          r.status     = ild_pkg::ST_INVALID;
        end
      end
      ild_pkg::OP_INS_HEAD: r.status = list_insert(0, cmd.item_value);
      ild_pkg::OP_INS_TAIL: r.status = list_insert(list_len, cmd.item_value);
      ild_pkg::OP_INS_BEFORE: begin
        if (p > list_len) r.status = ild_pkg::ST_INVALID;
        else if (p <= 0) r.status = list_insert(0, cmd.item_value);
        else r.status = list_insert(p, cmd.item_value);
      end
      ild_pkg::OP_DELETE: begin
        if (p >= 0 && p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else begin
          r.status = ild_pkg::ST_INVALID;
        end
      end
      default: r.status = ild_pkg::ST_INVALID;
    endcase
    r.length = list_len[ild_pkg::LEN_OUT_W-1:0];
    return r;
  endfunction

  function automatic ild_pkg::in_item_t mk_cmd(
    logic [ild_pkg::OPC_W-1:0] op,
    int                        pos,
    logic [ild_pkg::VAL_W-1:0] v
  );
    ild_pkg::in_item_t c;
    c.opcode     = op;
    c.position   = pos;
    c.item_value = v;
    return c;
  endfunction

  always @(posedge clk) begin : result_check
    ild_pkg::out_item_t exp_r;
    if (rst_n && out_valid) begin
      results_checked++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result value=%0d status=%0d length=%0d", $realtime,
                   out_item.read_value, out_item.status, out_item.length);
      end else begin
        exp_r = result_q.pop_front();
        if (out_item.read_value !== exp_r.read_value || out_item.status !== exp_r.status ||
            out_item.length !== exp_r.length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch expected value=%0d status=%0d length=%0d", $realtime,
                     exp_r.read_value, exp_r.status, exp_r.length);
            $display("%0t:          actual   value=%0d status=%0d length=%0d", $realtime,
                     out_item.read_value, out_item.status, out_item.length);
          end
        end
      end
    end
  end

  task automatic issue_cmd(input ild_pkg::in_item_t cmd);
    ild_pkg::out_item_t r;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = cmd;
    do @(posedge clk); while (busy);
    r = apply_list_cmd(cmd);
    result_q.push_back(r);
    cmds_sent++;
    if (r.status == ild_pkg::ST_FULL) full_drops++;
    if (r.status == ild_pkg::ST_INVALID) invalid_hits++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_empty_list();
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 0, 32'h1234_5678));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, -1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 32'sh8000_0000, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, 0, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, -1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, 1, 32'hDEAD_BEEF));
    issue_cmd(mk_cmd(OP_BAD_LO, 0, '1));
  endtask

  task automatic test_basic_ops();
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, -5, 32'd7));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_HEAD, 0, 32'h7FFF_FFFF));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_TAIL, 0, 32'h8000_0000));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, list_len, 32'h5555_5555));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, 2, 32'hAAAA_AAAA));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, 32'sh8000_0000, 32'hFFFF_FFFF));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 0, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, list_len - 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, list_len, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 32'sh7FFF_FFFF, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, 0, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, list_len - 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, list_len, '0));
    issue_cmd(mk_cmd(OP_BAD_MID, 3, 32'h0000_0001));
    issue_cmd(mk_cmd(OP_BAD_HI, -1, 32'h8000_0000));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 1, '0));
  endtask

  task automatic test_full_list();
    while (list_len < CAP) begin
      if ($urandom_range(1)) issue_cmd(mk_cmd(ild_pkg::OP_INS_TAIL, $urandom, $urandom));
      else issue_cmd(mk_cmd(ild_pkg::OP_INS_HEAD, $urandom, $urandom));
    end
    issue_cmd(mk_cmd(ild_pkg::OP_INS_HEAD, 0, 32'h0F0F_0F0F));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_TAIL, 0, 32'hF0F0_F0F0));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, list_len + 1, 32'h1111_1111));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, 10, 32'h2222_2222));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_BEFORE, list_len, 32'h3333_3333));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, CAP - 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_DELETE, CAP - 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, CAP - 1, '0));
    issue_cmd(mk_cmd(ild_pkg::OP_INS_HEAD, 0, 32'h4444_4444));
    issue_cmd(mk_cmd(ild_pkg::OP_GET, 0, '0));
    grow_mode = 1'b0;
  endtask

  function automatic ild_pkg::in_item_t rand_list_cmd();
    int                        r;
    int                        s;
    int                        pos;
    int                        ins_lim;
    int                        del_lim;
    logic [ild_pkg::OPC_W-1:0] op;
    if (list_len >= CAP) grow_mode = 1'b0;
    else if (list_len == 0) grow_mode = 1'b1;
    s = $urandom_range(99);
    if (s < 8) begin
      pos = $urandom;
    end else if (s < 18) begin
      case ($urandom_range(6))
        0: pos = -1;
        1: pos = 0;
        2: pos = list_len - 1;
        3: pos = list_len;
        4: pos = list_len + 1;
        5: pos = 32'sh8000_0000;
        default: pos = 32'sh7FFF_FFFF;
      endcase
    end else begin
      pos = $urandom_range(list_len);
    end
    ins_lim = grow_mode ? 74 : 19;
    del_lim = grow_mode ? 84 : 84;
    r = $urandom_range(99);
    if (r < 4) begin
      op = ild_pkg::OPC_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    end else if (r < ins_lim) begin
      op = ild_pkg::OPC_W'($urandom_range(ild_pkg::OP_INS_HEAD, ild_pkg::OP_INS_BEFORE));
    end else if (r < del_lim) begin
      op = ild_pkg::OP_DELETE;
    end else begin
      op = ild_pkg::OP_GET;
    end
    return mk_cmd(op, pos, $urandom);
  endfunction

  task automatic test_random(input int n);
    repeat (n) issue_cmd(rand_list_cmd());
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    list_len        = 0;
    grow_mode       = 1'b1;
    idle_pct        = 27;
    mismatches      = 0;
    results_checked = 0;
    cmds_sent       = 0;
    full_drops      = 0;
    invalid_hits    = 0;
    for (int i = 0; i < CAP; i++) list_mem[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_basic_ops();
    test_random(120);
    drain_results();

    idle_pct = 79;
    test_full_list();
    drain_results();
    test_random(120);
    drain_results();

    idle_pct = 0;
    test_random(120);
    drain_results();

    repeat (MAX_CMD_CYCLES) @(posedge clk);
    $display("Ran %0d list commands across empty, full and random fill/drain sweeps", cmds_sent);
    $display("  %0d results checked, %0d full drops, %0d invalid-index results",
             results_checked, full_drops, invalid_hits);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
